@@ sv/ttu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the tournament tree update engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ttu_pkg;

    localparam int KEY_W            = 32;
    localparam int OFFSET_W         = 13;
    localparam int NODE_W           = 10;
    localparam int MODE_W           = 2;
    localparam int TREE_ENTRIES_DEF = 1024;

    localparam logic [OFFSET_W-1:0] ALIGN_MASK     = OFFSET_W'(32'h0000_0007);
    localparam logic [OFFSET_W-1:0] CLEAR_LOW_MASK = OFFSET_W'(32'hFFFF_FFF8);

    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

    typedef enum logic [2:0] {
        ST_EQUAL  = 3'd0,
        ST_ROOT   = 3'd1,
        ST_SIGN   = 3'd2,
        ST_SPEC   = 3'd3,
        ST_ACCESS = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_ACC_WAIT,
        WS_LVL_RD,
        WS_LVL_CMP,
        WS_DONE
    } walk_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] payload;
    } node_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // Byte offset of the parent node: half the offset with the low three bits cleared.
    function automatic logic [OFFSET_W-1:0] parent_offset(input logic [OFFSET_W-1:0] off);
        return (off >> 1) & CLEAR_LOW_MASK;
    endfunction

endpackage

@@ sv/ttu_slot_map.sv @@
`timescale 1ns / 1ps
// Maps a node number onto a slot of the node memory, modulo the memory depth.
// Depends on ttu_pkg for the node number width.
module ttu_slot_map #(
    parameter int TREE_ENTRIES = ttu_pkg::TREE_ENTRIES_DEF
) (
    input  logic [ttu_pkg::NODE_W-1:0]       node_num,
    output logic [$clog2(TREE_ENTRIES)-1:0]  slot
);

    localparam int AW = $clog2(TREE_ENTRIES);

    generate
        if (TREE_ENTRIES >= (1 << ttu_pkg::NODE_W))
        begin : g_wide
            assign slot = AW'(node_num);
        end
        else if ((TREE_ENTRIES & (TREE_ENTRIES - 1)) == 0)
        begin : g_pow2
            assign slot = node_num[AW-1:0];
        end
        else
        begin : g_fold
            localparam int CW = ttu_pkg::NODE_W + AW;
            logic [CW-1:0] rem;

            // Restoring reduction: subtract the depth shifted down one bit per step.
            always_comb
            begin
                rem = CW'(node_num);
                for (int k = ttu_pkg::NODE_W - 1; k >= 0; k--)
                begin
                    if (rem >= (CW'(TREE_ENTRIES) << k))
                    begin
                        rem = rem - (CW'(TREE_ENTRIES) << k);
                    end
                end
            end

            assign slot = rem[AW-1:0];
        end
    endgenerate

endmodule

@@ sv/ttu_node_ram.sv @@
`timescale 1ns / 1ps
// Single-port node memory; read data is registered and appears in the cycle after the read enable.
// Depends on ttu_pkg for the node and control types.
module ttu_node_ram #(
    parameter int TREE_ENTRIES = ttu_pkg::TREE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  ttu_pkg::mem_ctl_t                ctl,
    input  logic [$clog2(TREE_ENTRIES)-1:0]  addr,
    input  ttu_pkg::node_t                   wr_node,
    output ttu_pkg::node_t                   rd_node
);

    ttu_pkg::node_t mem [TREE_ENTRIES];
    ttu_pkg::node_t rd_node_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_node;
        end
        if (ctl.rd_en)
        begin
            rd_node_reg <= mem[addr];
        end
    end

    assign rd_node = rd_node_reg;

endmodule

@@ sv/ttu_walk.sv @@
`timescale 1ns / 1ps
// Sequencer and datapath: node accesses, the climb towards the root and the result register.
// Depends on ttu_pkg; drives the node memory through ttu_slot_map and ttu_node_ram.
module ttu_walk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ttu_pkg::MODE_W-1:0]      mode,
    input  logic [ttu_pkg::NODE_W-1:0]      entry_index,
    input  logic [ttu_pkg::KEY_W-1:0]       entry_key,
    input  logic [ttu_pkg::KEY_W-1:0]       entry_payload,
    input  logic [ttu_pkg::KEY_W-1:0]       key_in,
    input  logic [ttu_pkg::KEY_W-1:0]       payload_in,
    input  logic [ttu_pkg::OFFSET_W-1:0]    node_offset,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [ttu_pkg::KEY_W-1:0]       key_out,
    output logic [ttu_pkg::KEY_W-1:0]       payload_out,
    output logic [ttu_pkg::KEY_W-1:0]       found_key,
    output logic [ttu_pkg::KEY_W-1:0]       found_payload,
    output logic [ttu_pkg::OFFSET_W-1:0]    offset_out,
    output ttu_pkg::mem_ctl_t               mem_ctl,
    output logic [ttu_pkg::NODE_W-1:0]      node_num,
    output ttu_pkg::node_t                  wr_node,
    input  ttu_pkg::node_t                  rd_node
);

    ttu_pkg::walk_state_t state_reg, state_next;

    ttu_pkg::status_t               status_reg, status_next;
    logic [ttu_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [ttu_pkg::KEY_W-1:0]      pay_reg, pay_next;
    logic [ttu_pkg::KEY_W-1:0]      fkey_reg, fkey_next;
    logic [ttu_pkg::KEY_W-1:0]      fpay_reg, fpay_next;
    logic [ttu_pkg::OFFSET_W-1:0]   off_reg, off_next;

    logic                           out_valid_reg, out_valid_next;
    ttu_pkg::status_t               out_status_reg, out_status_next;
    logic [ttu_pkg::KEY_W-1:0]      out_key_reg, out_key_next;
    logic [ttu_pkg::KEY_W-1:0]      out_pay_reg, out_pay_next;
    logic [ttu_pkg::KEY_W-1:0]      out_fkey_reg, out_fkey_next;
    logic [ttu_pkg::KEY_W-1:0]      out_fpay_reg, out_fpay_next;
    logic [ttu_pkg::OFFSET_W-1:0]   out_off_reg, out_off_next;

    logic [ttu_pkg::OFFSET_W-1:0]   up_off;
    logic [ttu_pkg::KEY_W-1:0]      carry_key;
    logic [ttu_pkg::KEY_W-1:0]      carry_pay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttu_pkg::WS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        fkey_reg       <= fkey_next;
        fpay_reg       <= fpay_next;
        off_reg        <= off_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_pay_reg    <= out_pay_next;
        out_fkey_reg   <= out_fkey_next;
        out_fpay_reg   <= out_fpay_next;
        out_off_reg    <= out_off_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        fkey_next       = fkey_reg;
        fpay_next       = fpay_reg;
        off_next        = off_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_pay_next    = out_pay_reg;
        out_fkey_next   = out_fkey_reg;
        out_fpay_next   = out_fpay_reg;
        out_off_next    = out_off_reg;
        mem_ctl         = '0;
        node_num        = off_reg[ttu_pkg::OFFSET_W-1:3];
        wr_node         = '{key: key_reg, payload: pay_reg};
        in_stall        = (state_reg != ttu_pkg::WS_IDLE);
        up_off          = ttu_pkg::parent_offset(off_reg);
        carry_key       = key_reg;
        carry_pay       = pay_reg;

        case (state_reg)
            ttu_pkg::WS_IDLE:
            begin
                node_num = entry_index;
                wr_node  = '{key: entry_key, payload: entry_payload};
                up_off   = ttu_pkg::parent_offset(node_offset);
                if (in_valid)
                begin
                    status_next = ttu_pkg::ST_SPEC;
                    key_next    = '0;
                    pay_next    = '0;
                    fkey_next   = '0;
                    fpay_next   = '0;
                    off_next    = '0;
                    state_next  = ttu_pkg::WS_DONE;
                    case (mode)
                        ttu_pkg::MODE_WRITE:
                        begin
                            mem_ctl.wr_en = 1'b1;
                            status_next   = ttu_pkg::ST_ACCESS;
                        end
                        ttu_pkg::MODE_READ:
                        begin
                            mem_ctl.rd_en = 1'b1;
                            status_next   = ttu_pkg::ST_ACCESS;
                            state_next    = ttu_pkg::WS_ACC_WAIT;
                        end
                        ttu_pkg::MODE_UPDATE:
                        begin
                            key_next = key_in;
                            pay_next = payload_in;
                            if ((node_offset & ttu_pkg::ALIGN_MASK) != '0)
                            begin
                                off_next = node_offset;
                            end
                            else if (up_off == '0)
                            begin
                                status_next = ttu_pkg::ST_ROOT;
                            end
                            else
                            begin
                                off_next = up_off;
                                if (key_in[ttu_pkg::KEY_W-1])
                                begin
                                    status_next = ttu_pkg::ST_SIGN;
                                end
                                else
                                begin
                                    state_next = ttu_pkg::WS_LVL_RD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ttu_pkg::WS_ACC_WAIT:
            begin
                fkey_next  = rd_node.key;
                fpay_next  = rd_node.payload;
                state_next = ttu_pkg::WS_DONE;
            end
            ttu_pkg::WS_LVL_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = ttu_pkg::WS_LVL_CMP;
            end
            ttu_pkg::WS_LVL_CMP:
            begin
                if (key_reg == rd_node.key)
                begin
                    status_next = ttu_pkg::ST_EQUAL;
                    fkey_next   = rd_node.key;
                    fpay_next   = rd_node.payload;
                    state_next  = ttu_pkg::WS_DONE;
                end
                else
                begin
                    // The smaller key stays in the node; the loser climbs on.
                    if (key_reg < rd_node.key)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        carry_key     = rd_node.key;
                        carry_pay     = rd_node.payload;
                    end
                    key_next = carry_key;
                    pay_next = carry_pay;
                    if (up_off == '0)
                    begin
                        status_next = ttu_pkg::ST_ROOT;
                        off_next    = '0;
                        state_next  = ttu_pkg::WS_DONE;
                    end
                    else
                    begin
                        off_next = up_off;
                        if (carry_key[ttu_pkg::KEY_W-1])
                        begin
                            status_next = ttu_pkg::ST_SIGN;
                            state_next  = ttu_pkg::WS_DONE;
                        end
                        else
                        begin
                            state_next = ttu_pkg::WS_LVL_RD;
                        end
                    end
                end
            end
            ttu_pkg::WS_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_key_next    = key_reg;
                    out_pay_next    = pay_reg;
                    out_fkey_next   = fkey_reg;
                    out_fpay_next   = fpay_reg;
                    out_off_next    = off_reg;
                    state_next      = ttu_pkg::WS_IDLE;
                end
            end
            default:
            begin
                state_next = ttu_pkg::WS_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign key_out       = out_key_reg;
    assign payload_out   = out_pay_reg;
    assign found_key     = out_fkey_reg;
    assign found_payload = out_fpay_reg;
    assign offset_out    = out_off_reg;

    a_mem_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("Node memory read and written in the same cycle.");

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttu_pkg::WS_LVL_CMP) |-> ($past(state_reg) == ttu_pkg::WS_LVL_RD))
        else $error("Compare step reached without a node read before it.");

    a_level_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttu_pkg::WS_LVL_RD) |->
        ((off_reg != '0) && ((off_reg & ttu_pkg::ALIGN_MASK) == '0)))
        else $error("Level read issued at the root or at an unaligned offset.");

    a_level_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttu_pkg::WS_LVL_RD) |-> !key_reg[ttu_pkg::KEY_W-1])
        else $error("Level read issued with the stop bit of the key set.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ttu_pkg::WS_DONE))
        else $error("Result presented without a finished item.");

endmodule

@@ sv/tournament_tree_update.sv @@
`timescale 1ns / 1ps
// Top level of the tournament tree update engine: sequencer, slot mapping and node memory.
// Depends on ttu_pkg, ttu_slot_map, ttu_node_ram and ttu_walk.
//
//   Channel | Direction | Handshake            | Fields
//   --------+-----------+----------------------+-----------------------------------------
//   in      | to block  | in_valid / in_stall  | mode, entry_index, entry_key,
//           |           |                      | entry_payload, key_in, payload_in,
//           |           |                      | node_offset
//   out     | from block| out_valid / out_stall| status, key_out, payload_out, found_key,
//           |           |                      | found_payload, offset_out
//
// One item is worked on at a time. A write passes from the idle state through the done state
// to the result register, a read also through the access wait state, and an update through a
// read state and a compare state for each tree level visited: each level is one read of the
// single-port node memory and one compare with an optional write-back. The result register
// lets the next item be taken while a result is still stalled. Reset clears only control
// state; the node memory holds nothing defined until written.
module tournament_tree_update #(
    parameter int TREE_ENTRIES = ttu_pkg::TREE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ttu_pkg::MODE_W-1:0]      mode,
    input  logic [ttu_pkg::NODE_W-1:0]      entry_index,
    input  logic [ttu_pkg::KEY_W-1:0]       entry_key,
    input  logic [ttu_pkg::KEY_W-1:0]       entry_payload,
    input  logic [ttu_pkg::KEY_W-1:0]       key_in,
    input  logic [ttu_pkg::KEY_W-1:0]       payload_in,
    input  logic [ttu_pkg::OFFSET_W-1:0]    node_offset,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [ttu_pkg::KEY_W-1:0]       key_out,
    output logic [ttu_pkg::KEY_W-1:0]       payload_out,
    output logic [ttu_pkg::KEY_W-1:0]       found_key,
    output logic [ttu_pkg::KEY_W-1:0]       found_payload,
    output logic [ttu_pkg::OFFSET_W-1:0]    offset_out
);

    localparam int AW = $clog2(TREE_ENTRIES);

    ttu_pkg::mem_ctl_t              mem_ctl;
    logic [ttu_pkg::NODE_W-1:0]     node_num;
    logic [AW-1:0]                  slot;
    ttu_pkg::node_t                 wr_node;
    ttu_pkg::node_t                 rd_node;

    ttu_walk u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .entry_index   (entry_index),
        .entry_key     (entry_key),
        .entry_payload (entry_payload),
        .key_in        (key_in),
        .payload_in    (payload_in),
        .node_offset   (node_offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .key_out       (key_out),
        .payload_out   (payload_out),
        .found_key     (found_key),
        .found_payload (found_payload),
        .offset_out    (offset_out),
        .mem_ctl       (mem_ctl),
        .node_num      (node_num),
        .wr_node       (wr_node),
        .rd_node       (rd_node)
    );

    ttu_slot_map #(
        .TREE_ENTRIES (TREE_ENTRIES)
    ) u_slot_map (
        .node_num (node_num),
        .slot     (slot)
    );

    ttu_node_ram #(
        .TREE_ENTRIES (TREE_ENTRIES)
    ) u_node_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (slot),
        .wr_node (wr_node),
        .rd_node (rd_node)
    );

endmodule
